[rtl/dvrt_pkg.sv]
// Shared types and constants of the distance-vector route table.
// No dependencies; dvrt_store and the route table import this package.
package dvrt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int MAX_OUT     = 32;

   localparam logic [4:0]  UNREACHABLE   = 5'd16;
   localparam logic [15:0] OWN_PORT_RST  = 16'd0;
   localparam logic [7:0]  EXPIRE_RST    = 8'd30;
   localparam logic [7:0]  GARBAGE_RST   = 8'd30;

   // item kinds
   localparam logic [1:0] REQ_ROUTE = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_ADV   = 2'd2;
   localparam logic [1:0] REQ_LOAD  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_OWN_PORT = 2'd0;
   localparam logic [1:0] CSR_EXPIRE   = 2'd1;
   localparam logic [1:0] CSR_GARBAGE  = 2'd2;

   typedef struct packed {
      logic [15:0] dest;
      logic [4:0]  cost;
      logic [15:0] hop;
      logic [7:0]  exp_cnt;
      logic [7:0]  gar_cnt;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } wr_type;

endpackage

[rtl/dvrt_ifs.sv]
// Handshake channels of the route table: request, response and register write.
// Depends on nothing.
interface dvrt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] peer_port;
   logic [15:0] route_dest;
   logic [7:0]  route_cost;
   logic        last_route;
   modport source(output valid, req_type, peer_port, route_dest, route_cost, last_route,
                  input ready);
   modport sink(input valid, req_type, peer_port, route_dest, route_cost, last_route,
                output ready);
endinterface

interface dvrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_dest;
   logic [4:0]  out_cost;
   logic        entry_present;
   logic        route_changed;
   logic        table_full_drop;
   logic [5:0]  entry_total;
   logic        last_result;
   modport source(output valid, out_dest, out_cost, entry_present, route_changed,
                  table_full_drop, entry_total, last_result, input ready);
   modport sink(input valid, out_dest, out_cost, entry_present, route_changed,
                table_full_drop, entry_total, last_result, output ready);
endinterface

interface dvrt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[rtl/dvrt_store.sv]
// Route entry storage: one combinational read port, one write port.
// Depends on dvrt_pkg.
module dvrt_store
   import dvrt_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry,
   input  wr_type           wr
);

   entry_type mem_ff [TABLE_DEPTH];

   // write of one whole entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.idx] <= wr.data;
      end
   end

   assign rd_entry = mem_ff[rd_idx];

endmodule

[rtl/distance_vector_route_table.sv]
// Route table of up to 32 entries walked one entry per cycle by a small sequencer; the
// advertise walk stalls while a listing entry waits on the response side. A route item
// runs a lookup walk and a merge unless it names the own port, and with last_route set
// a refresh walk; a tick runs one aging walk, an advertise one listing walk, and a load
// writes a single entry. The single entry read port is why each walk goes entry by entry. The final word of every item
// also waits while the previous word is still held on the response side.
// Depends on dvrt_pkg, dvrt_ifs and dvrt_store.
module distance_vector_route_table
   import dvrt_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   dvrt_req_if.sink   req_ch,
   dvrt_rsp_if.source rsp_ch,
   dvrt_csr_if.sink   csr_ch
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_MERGE, ST_REFRESH, ST_TICK, ST_ADV, ST_DONE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff, i_ff, w_ff, n_ff;
   logic [15:0]      own_port_ff;
   logic [7:0]       expire_limit_ff, garbage_limit_ff;

   logic [15:0]      peer_ff, rdest_ff;
   logic [7:0]       rcost_ff;
   logic             last_ff;
   logic [4:0]       scost_ff;
   logic             sfound_ff, hit_ff, changed_ff, drop_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic             pend_vld_ff;
   logic [15:0]      pend_dest_ff;
   logic [4:0]       pend_cost_ff;

   logic             rsp_vld_ff;
   logic [15:0]      rsp_dest_ff;
   logic [4:0]       rsp_cost_ff;
   logic             rsp_pres_ff, rsp_chg_ff, rsp_drop_ff, rsp_last_ff;
   logic [5:0]       rsp_total_ff;

   entry_type        rd;
   wr_type           wr;
   logic [IDX_W-1:0] rd_idx;
   logic             out_free, at_end, via, adv_skip, full, rsp_load;
   logic [8:0]       sum;
   logic [4:0]       through;
   entry_type        tick_entry;

   dvrt_store u_store (
      .clock    (clock),
      .rd_idx   (rd_idx),
      .rd_entry (rd),
      .wr       (wr)
   );

   assign out_free     = !rsp_vld_ff || rsp_ch.ready;
   assign at_end       = (i_ff == count_ff);
   assign full         = (count_ff == CNT_W'(TABLE_DEPTH));
   assign rd_idx       = (state_ff == ST_MERGE) ? hit_idx_ff : i_ff[IDX_W-1:0];
   assign via          = (rd.hop != 16'd0) && (rd.hop == peer_ff);
   assign adv_skip     = (rd.dest == peer_ff) || via;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   // a word enters the response register: a held-back listing entry or the final word
   assign rsp_load = ((state_ff == ST_ADV) && !at_end && (n_ff < CNT_W'(MAX_OUT)) &&
                      !adv_skip && pend_vld_ff && out_free) ||
                     ((state_ff == ST_DONE) && out_free);

   // shared saturating add of sender cost and advertised cost
   assign sum     = {4'd0, scost_ff} + {1'b0, rcost_ff};
   assign through = (sum > 9'(UNREACHABLE)) ? UNREACHABLE : sum[4:0];

   // aging of the entry under the walk
   always_comb begin
      tick_entry = rd;
      if (rd.exp_cnt >= expire_limit_ff) begin
         tick_entry.cost = UNREACHABLE;
         if (rd.gar_cnt != 8'hFF) tick_entry.gar_cnt = rd.gar_cnt + 8'd1;
      end else if (rd.exp_cnt != 8'hFF) begin
         tick_entry.exp_cnt = rd.exp_cnt + 8'd1;
      end
   end

   // write port selection
   always_comb begin
      wr      = '0;
      wr.data = rd;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.req_type == REQ_LOAD && !full) begin
               wr.en        = 1'b1;
               wr.idx       = count_ff[IDX_W-1:0];
               wr.data      = '0;
               wr.data.dest = req_ch.route_dest;
               wr.data.cost = (req_ch.route_cost > 8'(UNREACHABLE)) ? UNREACHABLE
                                                                  : req_ch.route_cost[4:0];
            end
         end
         ST_MERGE: begin
            if (hit_ff) begin
               wr.idx = hit_idx_ff;
               if (via) begin
                  wr.en        = 1'b1;
                  wr.data.cost = through;
               end else if (through < rd.cost) begin
                  wr.en        = 1'b1;
                  wr.data.cost = through;
                  wr.data.hop  = peer_ff;
               end
            end else if (!full) begin
               wr.en        = 1'b1;
               wr.idx       = count_ff[IDX_W-1:0];
               wr.data      = '0;
               wr.data.dest = rdest_ff;
               wr.data.cost = through;
               wr.data.hop  = peer_ff;
            end
         end
         ST_REFRESH: begin
            if (!at_end && (via || rd.dest == peer_ff) && rd.cost < UNREACHABLE) begin
               wr.en           = 1'b1;
               wr.idx          = i_ff[IDX_W-1:0];
               wr.data.exp_cnt = 8'd0;
               wr.data.gar_cnt = 8'd0;
            end
         end
         ST_TICK: begin
            if (!at_end && rd.gar_cnt < garbage_limit_ff) begin
               wr.en   = 1'b1;
               wr.idx  = w_ff[IDX_W-1:0];
               wr.data = tick_entry;
            end
         end
         default: ;
      endcase
   end

   // sequencer, registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         count_ff         <= '0;
         rsp_vld_ff       <= 1'b0;
         own_port_ff      <= OWN_PORT_RST;
         expire_limit_ff  <= EXPIRE_RST;
         garbage_limit_ff <= GARBAGE_RST;
      end else begin
         if (rsp_load)          rsp_vld_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_vld_ff <= 1'b0;

         // register writes
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_OWN_PORT: own_port_ff      <= csr_ch.data;
               CSR_EXPIRE:   expire_limit_ff  <= csr_ch.data[7:0];
               CSR_GARBAGE:  garbage_limit_ff <= csr_ch.data[7:0];
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  peer_ff     <= req_ch.peer_port;
                  rdest_ff    <= req_ch.route_dest;
                  rcost_ff    <= req_ch.route_cost;
                  last_ff     <= req_ch.last_route;
                  i_ff        <= '0;
                  w_ff        <= '0;
                  n_ff        <= '0;
                  scost_ff    <= UNREACHABLE;
                  sfound_ff   <= 1'b0;
                  hit_ff      <= 1'b0;
                  changed_ff  <= 1'b0;
                  drop_ff     <= 1'b0;
                  pend_vld_ff <= 1'b0;
                  case (req_ch.req_type)
                     REQ_ROUTE: begin
                        if (req_ch.route_dest != own_port_ff) state_ff <= ST_SCAN;
                        else if (req_ch.last_route)          state_ff <= ST_REFRESH;
                        else                                 state_ff <= ST_DONE;
                     end
                     REQ_TICK: state_ff <= ST_TICK;
                     REQ_ADV:  state_ff <= ST_ADV;
                     default: begin
                        if (full) drop_ff <= 1'b1;
                        else      count_ff <= count_ff + 1'b1;
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            // find sender cost and the matching destination
            ST_SCAN: begin
               if (at_end) begin
                  state_ff <= ST_MERGE;
               end else begin
                  if (!sfound_ff && rd.dest == peer_ff) begin
                     sfound_ff <= 1'b1;
                     scost_ff  <= rd.cost;
                  end
                  if (!hit_ff && rd.dest == rdest_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= i_ff[IDX_W-1:0];
                  end
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_MERGE: begin
               if (hit_ff) begin
                  if (!via && through < rd.cost) changed_ff <= 1'b1;
               end else if (full) begin
                  drop_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
               i_ff     <= '0;
               state_ff <= last_ff ? ST_REFRESH : ST_DONE;
            end
            ST_REFRESH: begin
               if (at_end) state_ff <= ST_DONE;
               else        i_ff     <= i_ff + 1'b1;
            end
            // age and compact in one pass
            ST_TICK: begin
               if (at_end) begin
                  count_ff <= w_ff;
                  state_ff <= ST_DONE;
               end else begin
                  if (rd.gar_cnt < garbage_limit_ff) w_ff <= w_ff + 1'b1;
                  i_ff <= i_ff + 1'b1;
               end
            end
            // one entry held back so the final word can carry last_result
            ST_ADV: begin
               if (at_end || n_ff >= CNT_W'(MAX_OUT)) begin
                  state_ff <= ST_DONE;
               end else if (adv_skip) begin
                  i_ff <= i_ff + 1'b1;
               end else if (!pend_vld_ff || out_free) begin
                  if (pend_vld_ff) begin
                     rsp_dest_ff  <= pend_dest_ff;
                     rsp_cost_ff  <= pend_cost_ff;
                     rsp_pres_ff  <= 1'b1;
                     rsp_chg_ff   <= 1'b0;
                     rsp_drop_ff  <= 1'b0;
                     rsp_last_ff  <= 1'b0;
                     rsp_total_ff <= 6'(count_ff);
                  end
                  pend_vld_ff  <= 1'b1;
                  pend_dest_ff <= rd.dest;
                  pend_cost_ff <= rd.cost;
                  n_ff         <= n_ff + 1'b1;
                  i_ff         <= i_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_dest_ff  <= pend_vld_ff ? pend_dest_ff : 16'd0;
                  rsp_cost_ff  <= pend_vld_ff ? pend_cost_ff : 5'd0;
                  rsp_pres_ff  <= pend_vld_ff;
                  rsp_chg_ff   <= changed_ff;
                  rsp_drop_ff  <= drop_ff;
                  rsp_last_ff  <= 1'b1;
                  rsp_total_ff <= 6'(count_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.out_dest        = rsp_dest_ff;
   assign rsp_ch.out_cost        = rsp_cost_ff;
   assign rsp_ch.entry_present   = rsp_pres_ff;
   assign rsp_ch.route_changed   = rsp_chg_ff;
   assign rsp_ch.table_full_drop = rsp_drop_ff;
   assign rsp_ch.entry_total     = rsp_total_ff;
   assign rsp_ch.last_result     = rsp_last_ff;

   // entry count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // an accepted item always starts the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer idle after accept");

   // aging never grows the table
   a_tick_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |=> (count_ff <= $past(count_ff)))
      else $error("table grew during aging");

   // compaction write pointer never passes the read pointer
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> (w_ff <= i_ff))
      else $error("compaction pointer ahead of walk");

endmodule
